// File: rtl/core/ptwr_pkg.sv
// Shared types and constants of the periodic timer with repeat bursts.
package ptwr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PERIOD_W   = 32;
    localparam int QTY_W      = 8;
    localparam int OP_W       = 2;
    localparam int NOW_W      = 32;
    localparam int IDX_OUT_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_QUANTITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSTPONE        = 3'd4;

    localparam logic [OP_W-1:0] OP_POLL     = 2'd0;
    localparam logic [OP_W-1:0] OP_START    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;

    typedef struct packed {
        logic load;
        logic div_go;
        logic div_sel_rep;
        logic div_base_rep;
        logic wr_start;
        logic wr_main;
        logic wr_rep_arm;
        logic wr_rep_step;
        logic wr_cnt_zero;
        logic out_load;
        logic out_fire;
        logic out_rep;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            main_hit;
        logic            rep_hit;
        logic            rep_en;
        logic            sync;
        logic            div_done;
    } t_dp_status;

endpackage

// File: rtl/core/ptwr_div.sv
// Bit-serial restoring divider that returns the remainder only.
module ptwr_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVS_W-1:0] o_rem,
    output logic             o_busy
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   dvs_ext;

    assign trial   = {r_rem, r_dvd[DVD_W-1]};
    assign dvs_ext = {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            if (trial >= dvs_ext) begin
                r_rem <= DVS_W'(trial - dvs_ext);
            end else begin
                r_rem <= DVS_W'(trial);
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_busy = r_busy;

endmodule

// File: rtl/core/ptwr_dp.sv
// Datapath: configuration, due times, repeat counter, divider and result register.
module ptwr_dp #(
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ptwr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptwr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [ptwr_pkg::OP_W-1:0]          i_operation,
    input  logic [ptwr_pkg::NOW_W-1:0]         i_now_seconds,
    input  ptwr_pkg::t_dp_cmd                  i_cmd,
    output ptwr_pkg::t_dp_status               o_status,
    output logic                               o_ready_res,
    output logic                               o_repeat_fire,
    output logic [ptwr_pkg::IDX_OUT_W-1:0]     o_repeat_index
);
    import ptwr_pkg::*;

    localparam int DW   = TIME_BITS + 1;
    localparam int SW   = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 2;
    localparam int CMPW = ((COUNT_BITS + 1) > QTY_W) ? (COUNT_BITS + 1) : QTY_W;
    localparam logic [SW-1:0] DUE_MAX = SW'({DW{1'b1}});

    logic [PERIOD_W-1:0]   r_period;
    logic [PERIOD_W-1:0]   r_rep_period;
    logic [QTY_W-1:0]      r_quantity;
    logic                  r_sync;
    logic                  r_postpone;
    logic [OP_W-1:0]       r_op;
    logic [TIME_BITS-1:0]  r_now;
    logic [DW-1:0]         r_next_due;
    logic [DW-1:0]         r_rep_due;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_ready_res;
    logic                  r_repeat_fire;
    logic [IDX_OUT_W-1:0]  r_repeat_index;

    logic [DW-1:0]         now_dw;
    logic [SW-1:0]         now_sw;
    logic [SW-1:0]         rem_sw;
    logic [DW-1:0]         div_base;
    logic [DW-1:0]         diff;
    logic [PERIOD_W-1:0]   divisor;
    logic [PERIOD_W-1:0]   rem;
    logic                  div_busy;
    logic [SW-1:0]         main_raw;
    logic [SW-1:0]         rep_raw;
    logic [SW-1:0]         start_raw;
    logic [DW-1:0]         main_adv;
    logic [DW-1:0]         rep_adv;
    logic [DW-1:0]         start_due;
    logic                  rep_en;
    logic [COUNT_BITS:0]   cnt_inc;
    logic [COUNT_BITS-1:0] cnt_step;

    function automatic logic [DW-1:0] sat_due(input logic [SW-1:0] x);
        return (x > DUE_MAX) ? DUE_MAX[DW-1:0] : x[DW-1:0];
    endfunction

    assign now_dw = DW'(r_now);
    assign now_sw = SW'(r_now);
    assign rem_sw = r_sync ? SW'(rem) : '0;

    // In sync mode the due time lands on the first grid point past now,
    // which is now minus the remainder plus one period.
    assign main_raw  = now_sw + SW'(r_period) - rem_sw;
    assign rep_raw   = now_sw + SW'(r_rep_period) - rem_sw;
    assign start_raw = now_sw + (r_postpone ? SW'(r_period) : '0);
    assign main_adv  = sat_due(main_raw);
    assign rep_adv   = sat_due(rep_raw);
    assign start_due = sat_due(start_raw);

    assign div_base = i_cmd.div_base_rep ? r_rep_due : r_next_due;
    assign diff     = now_dw - div_base;
    assign divisor  = i_cmd.div_sel_rep ? r_rep_period : r_period;

    assign rep_en = (r_rep_period != '0) && (r_rep_period < r_period) && (r_quantity != '0);

    assign cnt_inc  = (COUNT_BITS + 1)'(r_cnt) + 1'b1;
    assign cnt_step = ((CMPW'(cnt_inc) > CMPW'(r_quantity)) || cnt_inc[COUNT_BITS])
                      ? '0 : cnt_inc[COUNT_BITS-1:0];

    ptwr_div #(
        .DVD_W (TIME_BITS),
        .DVS_W (PERIOD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (diff[TIME_BITS-1:0]),
        .i_divisor  (divisor),
        .o_rem      (rem),
        .o_busy     (div_busy)
    );

    always_comb begin
        o_status.op       = r_op;
        o_status.main_hit = (r_period != '0) && (r_next_due <= now_dw);
        o_status.rep_hit  = rep_en && (r_cnt != '0) && (r_rep_due <= now_dw);
        o_status.rep_en   = rep_en;
        o_status.sync     = r_sync;
        o_status.div_done = !div_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= '0;
            r_rep_period <= '0;
            r_quantity   <= '0;
            r_sync       <= 1'b0;
            r_postpone   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PERIOD:          r_period     <= i_cfg_data;
                CFG_REPEAT_PERIOD:   r_rep_period <= i_cfg_data;
                CFG_REPEAT_QUANTITY: r_quantity   <= i_cfg_data[QTY_W-1:0];
                CFG_SYNC_MODE:       r_sync       <= i_cfg_data[0];
                CFG_POSTPONE:        r_postpone   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_due <= '0;
            r_rep_due  <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cmd.wr_start) begin
                r_next_due <= start_due;
                r_rep_due  <= start_due;
                r_cnt      <= '0;
            end
            if (i_cmd.wr_main) begin
                r_next_due <= main_adv;
            end
            if (i_cmd.wr_rep_arm) begin
                r_rep_due <= rep_adv;
                r_cnt     <= COUNT_BITS'(1);
            end
            if (i_cmd.wr_rep_step) begin
                r_rep_due <= rep_adv;
                r_cnt     <= cnt_step;
            end
            if (i_cmd.wr_cnt_zero) begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_now <= TIME_BITS'(i_now_seconds);
        end
        if (i_cmd.out_load) begin
            r_ready_res    <= i_cmd.out_fire;
            r_repeat_fire  <= i_cmd.out_rep;
            r_repeat_index <= IDX_OUT_W'(r_cnt);
        end
    end

    assign o_ready_res    = r_ready_res;
    assign o_repeat_fire  = r_repeat_fire;
    assign o_repeat_index = r_repeat_index;

endmodule

// File: rtl/core/ptwr_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module ptwr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  ptwr_pkg::t_dp_status i_status,
    output ptwr_pkg::t_dp_cmd    o_cmd
);
    import ptwr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_ARM,
        S_DIV_MAIN,
        S_DIV_STEP,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_fire, n_fire;
    logic   r_rep, n_rep;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_fire      = r_fire;
        n_rep       = r_rep;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.out_fire = r_fire;
        o_cmd.out_rep  = r_rep;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_fire     = 1'b0;
                    n_rep      = 1'b0;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_OUT;
                unique case (i_status.op)
                    OP_START: begin
                        o_cmd.wr_start = 1'b1;
                    end
                    OP_COMPLETE: begin
                        o_cmd.wr_cnt_zero = 1'b1;
                    end
                    OP_POLL: begin
                        if (i_status.main_hit) begin
                            n_fire = 1'b1;
                            if (i_status.rep_en) begin
                                if (i_status.sync) begin
                                    // Repeat grid first: it still needs the old due time.
                                    o_cmd.div_go      = 1'b1;
                                    o_cmd.div_sel_rep = 1'b1;
                                    n_state           = S_DIV_ARM;
                                end else begin
                                    o_cmd.wr_main    = 1'b1;
                                    o_cmd.wr_rep_arm = 1'b1;
                                end
                            end else begin
                                o_cmd.wr_cnt_zero = 1'b1;
                                if (i_status.sync) begin
                                    o_cmd.div_go = 1'b1;
                                    n_state      = S_DIV_MAIN;
                                end else begin
                                    o_cmd.wr_main = 1'b1;
                                end
                            end
                        end else if (i_status.rep_hit) begin
                            n_fire = 1'b1;
                            n_rep  = 1'b1;
                            if (i_status.sync) begin
                                o_cmd.div_go       = 1'b1;
                                o_cmd.div_sel_rep  = 1'b1;
                                o_cmd.div_base_rep = 1'b1;
                                n_state            = S_DIV_STEP;
                            end else begin
                                o_cmd.wr_rep_step = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_DIV_ARM: begin
                if (i_status.div_done) begin
                    o_cmd.wr_rep_arm = 1'b1;
                    o_cmd.div_go     = 1'b1;
                    n_state          = S_DIV_MAIN;
                end
            end
            S_DIV_MAIN: begin
                if (i_status.div_done) begin
                    o_cmd.wr_main = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_DIV_STEP: begin
                if (i_status.div_done) begin
                    o_cmd.wr_rep_step = 1'b1;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fire      <= 1'b0;
            r_rep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fire      <= n_fire;
            r_rep       <= n_rep;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/periodic_timer_with_repeats.sv
// Periodic due-time checker with repeat bursts: top level.
//
// Input channel (i_in_valid / o_in_stall) carries an operation (poll, start,
// complete) and the current time in seconds. Every input transaction yields
// exactly one result transaction on the output channel (o_out_valid /
// i_out_stall): ready_res, repeat_fire and the repeat counter after the item.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while no transaction is in
// flight, and the block does not enforce this. Start, complete and
// non-firing or non-sync polls pass from S_IDLE through S_EVAL and S_OUT
// back to S_IDLE. In sync mode a fire needs the remainder of the elapsed
// time by the period from the bit-serial divider: a repeat fire waits for
// one division, a main fire that arms a burst for two (repeat period first).
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver only holds back the following result.
// Synchronous reset clears the due times, the repeat counter and all
// configuration registers; no clearing pass is needed.
module periodic_timer_with_repeats #(
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ptwr_pkg::OP_W-1:0]          i_operation,
    input  logic [ptwr_pkg::NOW_W-1:0]         i_now_seconds,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_ready_res,
    output logic                               o_repeat_fire,
    output logic [ptwr_pkg::IDX_OUT_W-1:0]     o_repeat_index,
    input  logic                               i_cfg_we,
    input  logic [ptwr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptwr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ptwr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    ptwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ptwr_dp #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_now_seconds  (i_now_seconds),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_ready_res    (o_ready_res),
        .o_repeat_fire  (o_repeat_fire),
        .o_repeat_index (o_repeat_index)
    );

endmodule
